/* rtl/fractional_delay_echo_assert.svh */
// assertion macros for the fractional delay echo checker
`ifndef FRACTIONAL_DELAY_ECHO_ASSERT_SVH
`define FRACTIONAL_DELAY_ECHO_ASSERT_SVH

// consequent checked in the clock after the antecedent
`define FDE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// consequent checked in the same clock as the antecedent
`define FDE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/fde_pkg.sv */
// shared types, constants and helpers of the fractional delay echo
package fde_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int OPB_W      = 17;
	localparam int PROD_W     = 33;
	localparam int ACC_W      = 34;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIX   = 2'd2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [OPB_W-1:0]    coef_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	// register limits
	localparam sample_t            GAIN_MAX = 16'sd32440;
	localparam sample_t            GAIN_MIN = -16'sd32440;
	localparam logic [SAMPLE_W-1:0] MIX_FULL = 16'd32768;

	// rounding biases for the two output scalings
	localparam acc_t RND_Q8  = 34'sd128;
	localparam acc_t RND_Q15 = 34'sd16384;

	// saturation bounds
	localparam acc_t SAT_HI = 34'sd32767;
	localparam acc_t SAT_LO = -34'sd32768;

	// command from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic acc_load;
		logic rnd_q15;
	} mac_cmd_t;

	// clamp a scaled accumulator value to a 16-bit sample
	function automatic sample_t sat16(input acc_t v);
		sample_t r;
		if (v > SAT_HI) begin
			r = 16'sh7fff;
		end else if (v < SAT_LO) begin
			r = -16'sh8000;
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

/* rtl/fde_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module fde_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/fde_mac.sv */
// shared multiply-accumulate unit with registered product and rounding preload
module fde_mac (
	input  logic              clk,
	input  fde_pkg::mac_cmd_t cmd,
	input  fde_pkg::sample_t  op_a,
	input  fde_pkg::coef_t    op_b,
	output fde_pkg::acc_t     acc,
	output fde_pkg::acc_t     sum
);

	fde_pkg::prod_t prod_q;
	fde_pkg::acc_t  acc_q;
	fde_pkg::acc_t  base;

	// accumulate onto the rounding bias or onto the running total
	always_comb begin
		if (cmd.acc_load) begin
			base = cmd.rnd_q15 ? fde_pkg::RND_Q15 : fde_pkg::RND_Q8;
		end else begin
			base = acc_q;
		end
		sum = base + fde_pkg::acc_t'(prod_q);
	end

	// product register then accumulator register
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= fde_pkg::prod_t'(op_a) * fde_pkg::prod_t'(op_b);
		end
		if (cmd.acc_en) begin
			acc_q <= sum;
		end
	end

	assign acc = acc_q;

endmodule

/* rtl/fde_seq.sv */
// sequencer: read positions, operand steering, line write-back and output register
module fde_seq #(
	parameter int LINE_SIZE = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  fde_pkg::sample_t                   sample_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output fde_pkg::sample_t                   sample_out,
	input  logic [$clog2(LINE_SIZE)+7:0]       delay_q8,
	input  fde_pkg::sample_t                   feedback_gain,
	input  logic [fde_pkg::SAMPLE_W-1:0]       wet_mix,
	output logic                               ram_we,
	output logic [$clog2(LINE_SIZE)-1:0]       ram_waddr,
	output logic [fde_pkg::SAMPLE_W-1:0]       ram_wdata,
	output logic [$clog2(LINE_SIZE)-1:0]       ram_raddr,
	input  logic [fde_pkg::SAMPLE_W-1:0]       ram_rdata,
	output fde_pkg::mac_cmd_t                  cmd,
	output fde_pkg::sample_t                   op_a,
	output fde_pkg::coef_t                     op_b,
	input  fde_pkg::acc_t                      acc,
	input  fde_pkg::acc_t                      sum
);

	localparam int AW = $clog2(LINE_SIZE);
	localparam int PW = AW + 8;
	localparam logic [AW-1:0] LAST     = AW'(LINE_SIZE - 1);
	localparam logic [PW:0]   LINE_POS = (PW + 1)'(LINE_SIZE * 256);

	// state codes
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_A     = 4'd2;
	localparam logic [3:0] S_B     = 4'd3;
	localparam logic [3:0] S_D1    = 4'd4;
	localparam logic [3:0] S_D2    = 4'd5;
	localparam logic [3:0] S_F1    = 4'd6;
	localparam logic [3:0] S_F2    = 4'd7;
	localparam logic [3:0] S_M1    = 4'd8;

	logic [3:0]       state_q;
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    wp_next;
	logic [AW-1:0]    second_q;
	logic [7:0]       frac_q;
	fde_pkg::sample_t x_q;
	fde_pkg::sample_t delayed_q;
	logic             out_valid_q;
	fde_pkg::sample_t sample_out_q;

	logic [PW:0]      diff;
	logic [PW-1:0]    pos;
	logic [AW-1:0]    first;
	logic [AW-1:0]    second;
	logic [7:0]       frac;
	logic [8:0]       frac_inv;
	fde_pkg::sample_t delayed_w;
	fde_pkg::sample_t fb_w;
	logic             accept;
	logic             out_free;

	// read position behind the write pointer, wrapped once into the line
	always_comb begin
		diff = {1'b0, wp_q, 8'b0} - {1'b0, delay_q8};
		pos  = diff[PW] ? PW'(diff + LINE_POS) : diff[PW-1:0];
		first  = pos[PW-1:8];
		frac   = pos[7:0];
		second = (first == LAST) ? '0 : first + AW'(1);
	end

	assign wp_next   = (wp_q == LAST) ? '0 : wp_q + AW'(1);
	assign frac_inv  = 9'd256 - {1'b0, frac_q};
	assign delayed_w = fde_pkg::sample_t'(acc >>> 8);
	assign fb_w      = fde_pkg::sat16(acc >>> 15);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ready;

	// operand steering and memory control per step
	always_comb begin
		cmd       = '0;
		op_a      = x_q;
		op_b      = '0;
		ram_we    = 1'b0;
		ram_wdata = fb_w;
		ram_raddr = first;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = '0;
			end
			S_IDLE: begin
				ram_raddr = first;
			end
			S_A: begin
				// older tap times one minus fraction
				ram_raddr  = second_q;
				cmd.mul_en = 1'b1;
				op_a       = ram_rdata;
				op_b       = {8'b0, frac_inv};
			end
			S_B: begin
				// newer tap times fraction, start interpolation sum
				cmd.mul_en   = 1'b1;
				cmd.acc_en   = 1'b1;
				cmd.acc_load = 1'b1;
				op_a         = ram_rdata;
				op_b         = {9'b0, frac_q};
			end
			S_D1: begin
				// dry sample at unity for the feedback sum
				cmd.mul_en = 1'b1;
				cmd.acc_en = 1'b1;
				op_a       = x_q;
				op_b       = {1'b0, fde_pkg::MIX_FULL};
			end
			S_D2: begin
				// delayed sample times feedback gain
				cmd.mul_en   = 1'b1;
				cmd.acc_en   = 1'b1;
				cmd.acc_load = 1'b1;
				cmd.rnd_q15  = 1'b1;
				op_a         = delayed_w;
				op_b         = {feedback_gain[fde_pkg::SAMPLE_W-1], feedback_gain};
			end
			S_F1: begin
				// dry part of the mix
				cmd.mul_en = 1'b1;
				cmd.acc_en = 1'b1;
				op_a       = x_q;
				op_b       = {1'b0, fde_pkg::MIX_FULL} - {1'b0, wet_mix};
			end
			S_F2: begin
				// write back feedback value, wet part of the mix
				ram_we       = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.acc_en   = 1'b1;
				cmd.acc_load = 1'b1;
				cmd.rnd_q15  = 1'b1;
				op_a         = delayed_q;
				op_b         = {1'b0, wet_mix};
			end
			S_M1: begin
				ram_raddr = first;
			end
			default: begin
				ram_raddr = first;
			end
		endcase
	end

	assign ram_waddr = wp_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					wp_q <= wp_next;
					if (wp_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_A;
					end
				end
				S_A:  state_q <= S_B;
				S_B:  state_q <= S_D1;
				S_D1: state_q <= S_D2;
				S_D2: state_q <= S_F1;
				S_F1: state_q <= S_F2;
				S_F2: begin
					wp_q    <= wp_next;
					state_q <= S_M1;
				end
				S_M1: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// output beat handshake
			if ((state_q == S_M1) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q      <= sample_in;
			second_q <= second;
			frac_q   <= frac;
		end
		if (state_q == S_D2) begin
			delayed_q <= delayed_w;
		end
		if ((state_q == S_M1) && out_free) begin
			sample_out_q <= fde_pkg::sat16(sum >>> 15);
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

/* rtl/fractional_delay_echo.sv */
// top level of the fractional delay echo: configuration registers and unit wiring
//
//  channel   dir  handshake             payload
//  input     in   in_valid / in_ready   sample_in
//  output    out  out_valid / out_ready sample_out
//  config    in   cfg_we                cfg_index, cfg_data
//
// one sample goes through the accept cycle plus seven steps, set by the six
// products that go one at a time through the shared multiply-accumulate unit
// and the two line reads on the single ram read port.
// after reset the line ram is cleared one entry a cycle, all MAX_DELAY_SAMPLES + 2
// entries (4096 by default), with in_ready low; config writes are taken meanwhile.
// a waiting output beat holds the sequencer in its last step until it is taken.
module fractional_delay_echo #(
	parameter int MAX_DELAY_SAMPLES = 4094
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [fde_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [fde_pkg::SAMPLE_W-1:0] sample_out,
	input  logic                                cfg_we,
	input  logic [fde_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fde_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int LINE_SIZE = MAX_DELAY_SAMPLES + 2;
	localparam int AW        = $clog2(LINE_SIZE);
	localparam int DW        = AW + 8;
	localparam logic [24:0] DLY_MIN = 25'd256;
	localparam logic [24:0] DLY_MAX = 25'(MAX_DELAY_SAMPLES * 256);

	logic [DW-1:0]                  delay_q;
	fde_pkg::sample_t               gain_q;
	logic [fde_pkg::SAMPLE_W-1:0]   mix_q;

	logic [24:0]                    dly_ext;
	logic [24:0]                    dly_sat;
	fde_pkg::sample_t               gain_in;
	fde_pkg::sample_t               gain_sat;
	logic [fde_pkg::SAMPLE_W-1:0]   mix_in;
	logic [fde_pkg::SAMPLE_W-1:0]   mix_sat;

	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [fde_pkg::SAMPLE_W-1:0]   ram_wdata;
	logic [AW-1:0]                  ram_raddr;
	logic [fde_pkg::SAMPLE_W-1:0]   ram_rdata;
	fde_pkg::mac_cmd_t              cmd;
	fde_pkg::sample_t               op_a;
	fde_pkg::coef_t                 op_b;
	fde_pkg::acc_t                  acc;
	fde_pkg::acc_t                  sum;

	// clamp written values to each register's range
	always_comb begin
		dly_ext = {5'b0, cfg_data};
		if (dly_ext < DLY_MIN) begin
			dly_sat = DLY_MIN;
		end else if (dly_ext > DLY_MAX) begin
			dly_sat = DLY_MAX;
		end else begin
			dly_sat = dly_ext;
		end

		gain_in = cfg_data[fde_pkg::SAMPLE_W-1:0];
		if (gain_in > fde_pkg::GAIN_MAX) begin
			gain_sat = fde_pkg::GAIN_MAX;
		end else if (gain_in < fde_pkg::GAIN_MIN) begin
			gain_sat = fde_pkg::GAIN_MIN;
		end else begin
			gain_sat = gain_in;
		end

		mix_in  = cfg_data[fde_pkg::SAMPLE_W-1:0];
		mix_sat = (mix_in > fde_pkg::MIX_FULL) ? fde_pkg::MIX_FULL : mix_in;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DW'(256);
			gain_q  <= '0;
			mix_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fde_pkg::REG_DELAY: delay_q <= dly_sat[DW-1:0];
				fde_pkg::REG_GAIN:  gain_q  <= gain_sat;
				fde_pkg::REG_MIX:   mix_q   <= mix_sat;
				default: ;
			endcase
		end
	end

	// delay line store
	fde_ram #(
		.WIDTH(fde_pkg::SAMPLE_W),
		.DEPTH(LINE_SIZE)
	) u_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// shared arithmetic
	fde_mac u_mac (
		.clk (clk),
		.cmd (cmd),
		.op_a(op_a),
		.op_b(op_b),
		.acc (acc),
		.sum (sum)
	);

	// step sequencer
	fde_seq #(
		.LINE_SIZE(LINE_SIZE)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_in    (sample_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample_out   (sample_out),
		.delay_q8     (delay_q),
		.feedback_gain(gain_q),
		.wet_mix      (mix_q),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.cmd          (cmd),
		.op_a         (op_a),
		.op_b         (op_b),
		.acc          (acc),
		.sum          (sum)
	);

endmodule

/* rtl/fde_checker.sv */
// port-level checks of the fractional delay echo, bound to the top level
`include "fractional_delay_echo_assert.svh"

module fde_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [fde_pkg::SAMPLE_W-1:0] sample_out
);

	// a stalled output beat keeps its value
	`FDE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out), "output beat changed while stalled")

	// after an input beat the block stays busy before it takes another
	`FDE_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready ##1 !in_ready, "input taken again too soon")

	// a new result appears exactly as the sequencer returns to idle
	`FDE_ASSERT_SAME(a_result_at_idle, $rose(out_valid), in_ready, "result raised while still busy")

	// an idle block with no input stays ready
	`FDE_ASSERT_NEXT(a_idle_stays, in_ready && !in_valid, in_ready, "ready dropped without an input beat")

endmodule

bind fractional_delay_echo fde_checker u_fde_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sample_out(sample_out)
);
